// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL of the sorted key store.
// Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted store assertion failed");

// Next-cycle implication.
`define SLI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted store assertion failed");

`endif

// ===== design/sli_pkg.sv =====
package sli_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    // Operation codes on the kind field
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_DEL_CHK,
        S_DEL_CMP,
        S_SHF_CHK,
        S_SHF_WR,
        S_FINISH
    } state_t;

    // Outcome of the shared key comparator: stored entry against search key
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ===== design/sli_cmp.sv =====
module sli_cmp (
    input  logic signed [sli_pkg::KEY_W-1:0] entry,
    input  logic signed [sli_pkg::KEY_W-1:0] probe,
    output sli_pkg::cmp_res_t                res
);
    import sli_pkg::*;

    // Compare one stored entry against the operation key
    always_comb
    begin
        res.lt = (entry < probe);
        res.eq = (entry == probe);
        res.gt = (entry > probe);
    end

endmodule

// ===== design/sli_store.sv =====
module sli_store #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic signed [sli_pkg::KEY_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic signed [sli_pkg::KEY_W-1:0] rd_data
);
    import sli_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// Sorted key store: holds up to DEPTH signed 32-bit keys in ascending order.
// Input channel (in_valid/in_stall) takes one word: kind (0 insert, 1 delete)
// and key. Output channel (out_valid/out_stall) gives one word per input:
// status (done, not found, full), count held after it and the smallest key
// (zero when empty).
// Keys live in a single-port-write, registered-read memory; one comparator
// and a small sequencer walk it one entry at a time, each entry through a
// check state and then a compare or write state. An insert walks down from
// the end moving larger keys up; a delete scans up to the key and then
// moves the tail down. in_stall is high from the accepting edge until the
// sequencer is back in idle: for an insert until it reaches the bottom or
// stops at a smaller or equal key; for a delete until it has moved the tail
// after its key, runs past all keys or stops at a larger key; for a refused
// insert through the final step only. The result appears at the edge that
// ends it, and no new word is taken while one is in progress.
// The result sits in an output register, so the next word is accepted while
// a result waits under out_stall; the sequencer only waits at its final step
// if the previous result is still held.
// Reset clears the count and the handshake state; the memory is not cleared,
// since only entries below the count are ever used.
`include "assert_macros.svh"

module sorted_list_insert_delete #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic signed [sli_pkg::KEY_W-1:0]   key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [sli_pkg::COUNT_W-1:0]        count,
    output logic signed [sli_pkg::KEY_W-1:0]   smallest
);
    import sli_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t                 state_reg, state_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          count_reg, count_next;
    status_t                status_reg, status_next;
    logic signed [KEY_W-1:0] smallest_reg, smallest_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [CW-1:0]          out_count_reg, out_count_next;
    logic signed [KEY_W-1:0] out_smallest_reg, out_smallest_next;

    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic [CW-1:0]          ptr_inc;
    logic [CW-1:0]          ptr_dec;
    logic [CW-1:0]          rd_ptr;
    logic                   mem_we;
    logic [IW-1:0]          wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic signed [KEY_W-1:0] rd_data;
    cmp_res_t               cmp;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !(out_valid_reg && out_stall);
    assign full     = (count_reg == CW'(DEPTH));
    assign ptr_inc  = CW'(ptr_reg + 1'b1);
    assign ptr_dec  = CW'(ptr_reg - 1'b1);

    sli_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_ptr[IW-1:0]),
        .rd_data (rd_data)
    );

    sli_cmp u_cmp (
        .entry (rd_data),
        .probe (key_reg),
        .res   (cmp)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_DELETE)
                        state_next = S_DEL_CHK;
                    else if (full)
                        state_next = S_FINISH;
                    else
                        state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                state_next = (ptr_reg == '0) ? S_FINISH : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                state_next = cmp.gt ? S_INS_CHK : S_FINISH;
            end
            S_DEL_CHK:
            begin
                state_next = (ptr_reg == count_reg) ? S_FINISH : S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                if (cmp.lt)
                    state_next = S_DEL_CHK;
                else if (cmp.eq)
                    state_next = S_SHF_CHK;
                else
                    state_next = S_FINISH;
            end
            S_SHF_CHK:
            begin
                state_next = (ptr_inc == count_reg) ? S_FINISH : S_SHF_WR;
            end
            S_SHF_WR:
            begin
                state_next = S_SHF_CHK;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer datapath controls
    always_comb
    begin
        key_next    = key_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_ptr      = ptr_reg;
        mem_we      = 1'b0;
        wr_addr     = ptr_reg[IW-1:0];
        wr_data     = key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = key;
                    if (kind == KIND_DELETE)
                    begin
                        ptr_next    = '0;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        ptr_next    = count_reg;
                        status_next = full ? ST_FULL : ST_DONE;
                    end
                end
            end
            S_INS_CHK:
            begin
                // read the entry below the gap; at the bottom, drop the key in
                rd_ptr = ptr_dec;
                if (ptr_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            S_INS_CMP:
            begin
                rd_ptr = ptr_dec;
                mem_we = 1'b1;
                if (cmp.gt)
                begin
                    // move the larger key up and lower the gap
                    wr_data  = rd_data;
                    ptr_next = ptr_dec;
                end
                else
                begin
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            S_DEL_CHK:
            begin
                if (ptr_reg == count_reg)
                    status_next = ST_NOT_FOUND;
            end
            S_DEL_CMP:
            begin
                if (cmp.lt)
                    ptr_next = ptr_inc;
                else if (!cmp.eq)
                    status_next = ST_NOT_FOUND;
            end
            S_SHF_CHK:
            begin
                rd_ptr = ptr_inc;
                if (ptr_inc == count_reg)
                    count_next = CW'(count_reg - 1'b1);
            end
            S_SHF_WR:
            begin
                // pull the next entry down into the hole
                rd_ptr   = ptr_inc;
                mem_we   = 1'b1;
                wr_data  = rd_data;
                ptr_next = ptr_inc;
            end
            S_FINISH:
            begin
                rd_ptr = ptr_reg;
            end
            default:
            begin
                rd_ptr = ptr_reg;
            end
        endcase
    end

    // Track the head entry alongside the memory
    always_comb
    begin
        smallest_next = smallest_reg;
        if (mem_we && (wr_addr == '0))
            smallest_next = wr_data;
    end

    // Output register: load at the final step, drop once taken
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;
        out_smallest_next = out_smallest_reg;
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next    = 1'b1;
            out_status_next   = status_reg;
            out_count_next    = count_reg;
            out_smallest_next = (count_reg == '0) ? '0 : smallest_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        ptr_reg          <= ptr_next;
        status_reg       <= status_next;
        smallest_reg     <= smallest_next;
        out_status_reg   <= out_status_next;
        out_count_reg    <= out_count_next;
        out_smallest_reg <= out_smallest_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign count     = COUNT_W'(out_count_reg);
    assign smallest  = out_smallest_reg;

    // Checks
    `SLI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `SLI_ASSERT_NXT(a_busy_after_accept, accept, state_reg != S_IDLE)
    `SLI_ASSERT_IMP(a_full_means_full, out_valid_reg && (out_status_reg == ST_FULL), out_count_reg == CW'(DEPTH))
    `SLI_ASSERT_IMP(a_empty_smallest, out_valid_reg && (out_count_reg == '0), out_smallest_reg == '0)

endmodule
